/* rtl/core/vt2d_pkg.sv */
package vt2d_pkg;

    localparam int DEF_COORD_WIDTH     = 16;
    localparam int DEF_SCALE_FRAC_BITS = 8;
    localparam int DEF_TRIG_FRAC_BITS  = 14;

    localparam int SCALE_WIDTH     = 16;
    localparam int ANGLE_WIDTH     = 9;
    localparam int TABLE_FRAC_BITS = 14;
    localparam int TABLE_WIDTH     = 15;
    localparam int TABLE_INDEX_W   = 7;
    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [ANGLE_WIDTH-1:0] DEG_QUARTER = 9'd90;
    localparam logic [ANGLE_WIDTH-1:0] DEG_HALF    = 9'd180;
    localparam logic [ANGLE_WIDTH-1:0] DEG_3QUART  = 9'd270;
    localparam logic [ANGLE_WIDTH-1:0] DEG_FULL    = 9'd360;

    localparam logic signed [SCALE_WIDTH-1:0] SCALE_RESET = 16'sd256;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFFSET_X = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFFSET_Y = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCALE_X  = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCALE_Y  = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PIVOT_X  = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PIVOT_Y  = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ANGLE    = 3'd7;

    typedef enum logic [1:0] {
        MODE_TRANSLATE = 2'd0,
        MODE_SCALE     = 2'd1,
        MODE_ROTATE    = 2'd2,
        MODE_PASS      = 2'd3
    } mode_t;

    typedef struct packed {
        logic  valid;
        mode_t mode;
        logic  last;
    } ctl_t;

    // round(sin(d deg) * 2^14), d = 0..90
    localparam logic [TABLE_WIDTH-1:0] QUARTER_SINE [91] = '{
            15'd0,   15'd286,   15'd572,   15'd857,  15'd1143,
         15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
         15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
         15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
         15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
         15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
         15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
         15'd9397,  15'd9630,  15'd9860, 15'd10087, 15'd10311,
        15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
        15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
        15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
        15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
        15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
        15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
        15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
        15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
        15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
        15'd16384
    };

endpackage

/* rtl/core/vertex_2d_transform.sv */
// stages are operand select, multiply, sum, round and clamp; each vertex passes them in order
// throughput: one vertex per cycle while out_stall is low
// a stage only holds when it is full and the stage after it cannot take its word
// reset clears every valid bit and returns the registers to defaults: translate mode,
// zero offsets and pivot, unit scale on both axes, zero angle
module vertex_2d_transform #(
    parameter int  COORD_WIDTH     = vt2d_pkg::DEF_COORD_WIDTH,
    parameter int  SCALE_FRAC_BITS = vt2d_pkg::DEF_SCALE_FRAC_BITS,
    parameter int  TRIG_FRAC_BITS  = vt2d_pkg::DEF_TRIG_FRAC_BITS,
    localparam int CFG_DATA_WIDTH  = (COORD_WIDTH > vt2d_pkg::SCALE_WIDTH) ?
                                     COORD_WIDTH : vt2d_pkg::SCALE_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [vt2d_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]            cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [COORD_WIDTH-1:0]        pos_x,
    input  logic signed [COORD_WIDTH-1:0]        pos_y,
    input  logic                                 last_vertex,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [COORD_WIDTH-1:0]        out_x,
    output logic signed [COORD_WIDTH-1:0]        out_y,
    output logic                                 clipped,
    output logic                                 end_of_polygon
);
    import vt2d_pkg::*;

    localparam int TW  = TRIG_FRAC_BITS + 2;
    localparam int DXW = COORD_WIDTH + 1;
    localparam int BW  = (TW > SCALE_WIDTH) ? TW : SCALE_WIDTH;
    localparam int BSW = COORD_WIDTH + TRIG_FRAC_BITS + 1;
    localparam int PW  = DXW + BW;

    mode_t                         cfg_mode;
    logic signed [COORD_WIDTH-1:0] offset_x;
    logic signed [COORD_WIDTH-1:0] offset_y;
    logic signed [SCALE_WIDTH-1:0] scale_x;
    logic signed [SCALE_WIDTH-1:0] scale_y;
    logic signed [COORD_WIDTH-1:0] pivot_x;
    logic signed [COORD_WIDTH-1:0] pivot_y;
    logic signed [TW-1:0]          sin_val;
    logic signed [TW-1:0]          cos_val;

    ctl_t                  in_ctl;
    ctl_t                  s1_ctl;
    ctl_t                  s2_ctl;
    ctl_t                  s3_ctl;
    ctl_t                  s4_ctl;
    logic signed [DXW-1:0] op_a [4];
    logic signed [BW-1:0]  op_b [4];
    logic signed [BSW-1:0] s1_base_x;
    logic signed [BSW-1:0] s1_base_y;
    logic signed [PW-1:0]  prod [4];
    logic signed [BSW-1:0] s2_base_x;
    logic signed [BSW-1:0] s2_base_y;

    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy4;

    // each stage loads when it is empty or its word moves on
    assign rdy4 = !s4_ctl.valid || !out_stall;
    assign rdy3 = !s3_ctl.valid || rdy4;
    assign rdy2 = !s2_ctl.valid || rdy3;
    assign rdy1 = !s1_ctl.valid || rdy2;

    assign in_stall = !rdy1;

    always_comb
    begin
        in_ctl.valid = in_valid;
        in_ctl.mode  = cfg_mode;
        in_ctl.last  = last_vertex;
    end

    vt2d_cfg #(
        .COORD_WIDTH    (COORD_WIDTH),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
        .DATA_WIDTH     (CFG_DATA_WIDTH)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_wr_en),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .mode     (cfg_mode),
        .offset_x (offset_x),
        .offset_y (offset_y),
        .scale_x  (scale_x),
        .scale_y  (scale_y),
        .pivot_x  (pivot_x),
        .pivot_y  (pivot_y),
        .sin_val  (sin_val),
        .cos_val  (cos_val)
    );

    vt2d_front #(
        .COORD_WIDTH    (COORD_WIDTH),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
        .DXW            (DXW),
        .BW             (BW),
        .BSW            (BSW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (rdy1),
        .in_ctl   (in_ctl),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .offset_x (offset_x),
        .offset_y (offset_y),
        .scale_x  (scale_x),
        .scale_y  (scale_y),
        .pivot_x  (pivot_x),
        .pivot_y  (pivot_y),
        .sin_val  (sin_val),
        .cos_val  (cos_val),
        .out_ctl  (s1_ctl),
        .op_a     (op_a),
        .op_b     (op_b),
        .base_x   (s1_base_x),
        .base_y   (s1_base_y)
    );

    vt2d_mul #(
        .DXW (DXW),
        .BW  (BW),
        .BSW (BSW),
        .PW  (PW)
    ) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (rdy2),
        .in_ctl    (s1_ctl),
        .op_a      (op_a),
        .op_b      (op_b),
        .in_base_x (s1_base_x),
        .in_base_y (s1_base_y),
        .out_ctl   (s2_ctl),
        .prod      (prod),
        .base_x    (s2_base_x),
        .base_y    (s2_base_y)
    );

    vt2d_back #(
        .COORD_WIDTH     (COORD_WIDTH),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS),
        .TRIG_FRAC_BITS  (TRIG_FRAC_BITS),
        .PW              (PW),
        .BSW             (BSW)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .en_sum  (rdy3),
        .en_out  (rdy4),
        .in_ctl  (s2_ctl),
        .prod    (prod),
        .base_x  (s2_base_x),
        .base_y  (s2_base_y),
        .sum_ctl (s3_ctl),
        .out_ctl (s4_ctl),
        .out_x   (out_x),
        .out_y   (out_y),
        .clipped (clipped)
    );

    assign out_valid      = s4_ctl.valid;
    assign end_of_polygon = s4_ctl.last;

endmodule

/* rtl/core/vt2d_cfg.sv */
module vt2d_cfg #(
    parameter int COORD_WIDTH    = vt2d_pkg::DEF_COORD_WIDTH,
    parameter int TRIG_FRAC_BITS = vt2d_pkg::DEF_TRIG_FRAC_BITS,
    parameter int DATA_WIDTH     = vt2d_pkg::SCALE_WIDTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   wr_en,
    input  logic [vt2d_pkg::CFG_INDEX_WIDTH-1:0]   wr_index,
    input  logic [DATA_WIDTH-1:0]                  wr_data,
    output vt2d_pkg::mode_t                        mode,
    output logic signed [COORD_WIDTH-1:0]          offset_x,
    output logic signed [COORD_WIDTH-1:0]          offset_y,
    output logic signed [vt2d_pkg::SCALE_WIDTH-1:0] scale_x,
    output logic signed [vt2d_pkg::SCALE_WIDTH-1:0] scale_y,
    output logic signed [COORD_WIDTH-1:0]          pivot_x,
    output logic signed [COORD_WIDTH-1:0]          pivot_y,
    output logic signed [TRIG_FRAC_BITS+1:0]       sin_val,
    output logic signed [TRIG_FRAC_BITS+1:0]       cos_val
);
    import vt2d_pkg::*;

    localparam int TW  = TRIG_FRAC_BITS + 2;
    localparam int EW  = (TRIG_FRAC_BITS + 2 > 16) ? TRIG_FRAC_BITS + 2 : 16;
    localparam int UP  = (TRIG_FRAC_BITS >= TABLE_FRAC_BITS) ? TRIG_FRAC_BITS - TABLE_FRAC_BITS : 0;
    localparam int DN  = (TRIG_FRAC_BITS < TABLE_FRAC_BITS) ? TABLE_FRAC_BITS - TRIG_FRAC_BITS : 0;
    localparam int RND = (DN > 0) ? (1 << (DN - 1)) : 0;
    localparam logic signed [TW-1:0] TRIG_ONE = TW'(1) <<< TRIG_FRAC_BITS;

    mode_t                         mode_reg;
    logic signed [COORD_WIDTH-1:0] offset_x_reg;
    logic signed [COORD_WIDTH-1:0] offset_y_reg;
    logic signed [SCALE_WIDTH-1:0] scale_x_reg;
    logic signed [SCALE_WIDTH-1:0] scale_y_reg;
    logic signed [COORD_WIDTH-1:0] pivot_x_reg;
    logic signed [COORD_WIDTH-1:0] pivot_y_reg;
    logic signed [TW-1:0]          sin_reg;
    logic signed [TW-1:0]          cos_reg;

    logic [ANGLE_WIDTH-1:0] angle_raw;
    logic [ANGLE_WIDTH-1:0] angle_red;
    logic [ANGLE_WIDTH:0]   angle_cos_sum;
    logic [ANGLE_WIDTH-1:0] angle_cos;

    function automatic logic signed [TW-1:0] sine_deg(input logic [ANGLE_WIDTH-1:0] a);
        logic [1:0]               q;
        logic [ANGLE_WIDTH-1:0]   r_full;
        logic [TABLE_INDEX_W-1:0] r;
        logic [TABLE_INDEX_W-1:0] idx;
        logic [EW-1:0]            e;
        logic signed [TW-1:0]     t;
        priority if (a < DEG_QUARTER)
        begin
            q      = 2'd0;
            r_full = a;
        end
        else if (a < DEG_HALF)
        begin
            q      = 2'd1;
            r_full = a - DEG_QUARTER;
        end
        else if (a < DEG_3QUART)
        begin
            q      = 2'd2;
            r_full = a - DEG_HALF;
        end
        else
        begin
            q      = 2'd3;
            r_full = a - DEG_3QUART;
        end
        r   = r_full[TABLE_INDEX_W-1:0];
        idx = q[0] ? (TABLE_INDEX_W'(DEG_QUARTER) - r) : r;
        e   = ((EW'(QUARTER_SINE[idx]) + EW'(RND)) >> DN) << UP;
        t   = signed'(e[TW-1:0]);
        return q[1] ? -t : t;
    endfunction

    // angle wraps once past a full turn; cosine is sine a quarter turn on
    always_comb
    begin
        angle_raw     = wr_data[ANGLE_WIDTH-1:0];
        angle_red     = (angle_raw >= DEG_FULL) ? angle_raw - DEG_FULL : angle_raw;
        angle_cos_sum = {1'b0, angle_red} + {1'b0, DEG_QUARTER};
        angle_cos     = (angle_cos_sum >= {1'b0, DEG_FULL}) ?
                        ANGLE_WIDTH'(angle_cos_sum - {1'b0, DEG_FULL}) :
                        angle_cos_sum[ANGLE_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_TRANSLATE;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            scale_x_reg  <= SCALE_RESET;
            scale_y_reg  <= SCALE_RESET;
            pivot_x_reg  <= '0;
            pivot_y_reg  <= '0;
            sin_reg      <= '0;
            cos_reg      <= TRIG_ONE;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_MODE:     mode_reg     <= mode_t'(wr_data[1:0]);
                REG_OFFSET_X: offset_x_reg <= signed'(wr_data[COORD_WIDTH-1:0]);
                REG_OFFSET_Y: offset_y_reg <= signed'(wr_data[COORD_WIDTH-1:0]);
                REG_SCALE_X:  scale_x_reg  <= signed'(wr_data[SCALE_WIDTH-1:0]);
                REG_SCALE_Y:  scale_y_reg  <= signed'(wr_data[SCALE_WIDTH-1:0]);
                REG_PIVOT_X:  pivot_x_reg  <= signed'(wr_data[COORD_WIDTH-1:0]);
                REG_PIVOT_Y:  pivot_y_reg  <= signed'(wr_data[COORD_WIDTH-1:0]);
                REG_ANGLE:
                begin
                    sin_reg <= sine_deg(angle_red);
                    cos_reg <= sine_deg(angle_cos);
                end
            endcase
        end
    end

    assign mode     = mode_reg;
    assign offset_x = offset_x_reg;
    assign offset_y = offset_y_reg;
    assign scale_x  = scale_x_reg;
    assign scale_y  = scale_y_reg;
    assign pivot_x  = pivot_x_reg;
    assign pivot_y  = pivot_y_reg;
    assign sin_val  = sin_reg;
    assign cos_val  = cos_reg;

endmodule

/* rtl/core/vt2d_front.sv */
module vt2d_front #(
    parameter int COORD_WIDTH    = vt2d_pkg::DEF_COORD_WIDTH,
    parameter int TRIG_FRAC_BITS = vt2d_pkg::DEF_TRIG_FRAC_BITS,
    parameter int DXW            = COORD_WIDTH + 1,
    parameter int BW             = vt2d_pkg::SCALE_WIDTH,
    parameter int BSW            = COORD_WIDTH + TRIG_FRAC_BITS + 1
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  vt2d_pkg::ctl_t                          in_ctl,
    input  logic signed [COORD_WIDTH-1:0]           pos_x,
    input  logic signed [COORD_WIDTH-1:0]           pos_y,
    input  logic signed [COORD_WIDTH-1:0]           offset_x,
    input  logic signed [COORD_WIDTH-1:0]           offset_y,
    input  logic signed [vt2d_pkg::SCALE_WIDTH-1:0] scale_x,
    input  logic signed [vt2d_pkg::SCALE_WIDTH-1:0] scale_y,
    input  logic signed [COORD_WIDTH-1:0]           pivot_x,
    input  logic signed [COORD_WIDTH-1:0]           pivot_y,
    input  logic signed [TRIG_FRAC_BITS+1:0]        sin_val,
    input  logic signed [TRIG_FRAC_BITS+1:0]        cos_val,
    output vt2d_pkg::ctl_t                          out_ctl,
    output logic signed [DXW-1:0]                   op_a [4],
    output logic signed [BW-1:0]                    op_b [4],
    output logic signed [BSW-1:0]                   base_x,
    output logic signed [BSW-1:0]                   base_y
);
    import vt2d_pkg::*;

    ctl_t                  ctl_reg;
    logic signed [DXW-1:0] op_a_reg [4];
    logic signed [BW-1:0]  op_b_reg [4];
    logic signed [BSW-1:0] base_x_reg;
    logic signed [BSW-1:0] base_y_reg;

    logic signed [DXW-1:0] op_a_next [4];
    logic signed [BW-1:0]  op_b_next [4];
    logic signed [BSW-1:0] base_x_next;
    logic signed [BSW-1:0] base_y_next;

    logic signed [DXW-1:0] x_ext;
    logic signed [DXW-1:0] y_ext;
    logic signed [DXW-1:0] dx;
    logic signed [DXW-1:0] dy;

    always_comb
    begin
        x_ext = DXW'(pos_x);
        y_ext = DXW'(pos_y);
        dx    = x_ext - DXW'(pivot_x);
        dy    = y_ext - DXW'(pivot_y);

        op_a_next[0] = x_ext;
        op_a_next[1] = dy;
        op_a_next[2] = y_ext;
        op_a_next[3] = dy;
        for (int k = 0; k < 4; k++)
        begin
            op_b_next[k] = '0;
        end
        base_x_next = BSW'(x_ext);
        base_y_next = BSW'(y_ext);

        // x term: p0 - p1, y term: p2 + p3
        unique case (in_ctl.mode)
            MODE_TRANSLATE:
            begin
                base_x_next = BSW'(x_ext + DXW'(offset_x));
                base_y_next = BSW'(y_ext + DXW'(offset_y));
            end
            MODE_SCALE:
            begin
                op_b_next[0] = BW'(scale_x);
                op_b_next[2] = BW'(scale_y);
                base_x_next  = '0;
                base_y_next  = '0;
            end
            MODE_ROTATE:
            begin
                op_a_next[0] = dx;
                op_a_next[2] = dx;
                op_b_next[0] = BW'(cos_val);
                op_b_next[1] = BW'(sin_val);
                op_b_next[2] = BW'(sin_val);
                op_b_next[3] = BW'(cos_val);
                base_x_next  = BSW'(pivot_x) <<< TRIG_FRAC_BITS;
                base_y_next  = BSW'(pivot_y) <<< TRIG_FRAC_BITS;
            end
            MODE_PASS:
            begin
                base_x_next = BSW'(x_ext);
                base_y_next = BSW'(y_ext);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_a_reg   <= op_a_next;
            op_b_reg   <= op_b_next;
            base_x_reg <= base_x_next;
            base_y_reg <= base_y_next;
        end
    end

    assign out_ctl = ctl_reg;
    assign op_a    = op_a_reg;
    assign op_b    = op_b_reg;
    assign base_x  = base_x_reg;
    assign base_y  = base_y_reg;

endmodule

/* rtl/core/vt2d_mul.sv */
module vt2d_mul #(
    parameter int DXW = vt2d_pkg::DEF_COORD_WIDTH + 1,
    parameter int BW  = vt2d_pkg::SCALE_WIDTH,
    parameter int BSW = vt2d_pkg::DEF_COORD_WIDTH + vt2d_pkg::DEF_TRIG_FRAC_BITS + 1,
    parameter int PW  = DXW + BW
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  vt2d_pkg::ctl_t        in_ctl,
    input  logic signed [DXW-1:0] op_a [4],
    input  logic signed [BW-1:0]  op_b [4],
    input  logic signed [BSW-1:0] in_base_x,
    input  logic signed [BSW-1:0] in_base_y,
    output vt2d_pkg::ctl_t        out_ctl,
    output logic signed [PW-1:0]  prod [4],
    output logic signed [BSW-1:0] base_x,
    output logic signed [BSW-1:0] base_y
);
    import vt2d_pkg::*;

    ctl_t                  ctl_reg;
    logic signed [PW-1:0]  prod_reg [4];
    logic signed [BSW-1:0] base_x_reg;
    logic signed [BSW-1:0] base_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                prod_reg[k] <= PW'(op_a[k]) * PW'(op_b[k]);
            end
            base_x_reg <= in_base_x;
            base_y_reg <= in_base_y;
        end
    end

    assign out_ctl = ctl_reg;
    assign prod    = prod_reg;
    assign base_x  = base_x_reg;
    assign base_y  = base_y_reg;

endmodule

/* rtl/core/vt2d_back.sv */
module vt2d_back #(
    parameter int COORD_WIDTH     = vt2d_pkg::DEF_COORD_WIDTH,
    parameter int SCALE_FRAC_BITS = vt2d_pkg::DEF_SCALE_FRAC_BITS,
    parameter int TRIG_FRAC_BITS  = vt2d_pkg::DEF_TRIG_FRAC_BITS,
    parameter int PW              = 2 * vt2d_pkg::DEF_COORD_WIDTH + 1,
    parameter int BSW             = COORD_WIDTH + TRIG_FRAC_BITS + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en_sum,
    input  logic                          en_out,
    input  vt2d_pkg::ctl_t                in_ctl,
    input  logic signed [PW-1:0]          prod [4],
    input  logic signed [BSW-1:0]         base_x,
    input  logic signed [BSW-1:0]         base_y,
    output vt2d_pkg::ctl_t                sum_ctl,
    output vt2d_pkg::ctl_t                out_ctl,
    output logic signed [COORD_WIDTH-1:0] out_x,
    output logic signed [COORD_WIDTH-1:0] out_y,
    output logic                          clipped
);
    import vt2d_pkg::*;

    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] SAT_HI     = SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_LO     = ~SAT_HI;
    localparam logic signed [SW-1:0] SCALE_MASK = SW'((1 << SCALE_FRAC_BITS) - 1);
    localparam logic signed [SW-1:0] TRIG_MASK  = SW'((1 << TRIG_FRAC_BITS) - 1);

    ctl_t                          sum_ctl_reg;
    logic signed [SW-1:0]          sum_x_reg;
    logic signed [SW-1:0]          sum_y_reg;
    ctl_t                          out_ctl_reg;
    logic signed [COORD_WIDTH-1:0] out_x_reg;
    logic signed [COORD_WIDTH-1:0] out_y_reg;
    logic                          clipped_reg;

    logic signed [SW-1:0]          mask;
    logic signed [SW-1:0]          res_x;
    logic signed [SW-1:0]          res_y;
    logic                          clip_x;
    logic                          clip_y;
    logic signed [COORD_WIDTH-1:0] sat_x;
    logic signed [COORD_WIDTH-1:0] sat_y;

    function automatic logic signed [SW-1:0] trunc_shift(
        input logic signed [SW-1:0] v,
        input logic signed [SW-1:0] m,
        input mode_t                md
    );
        logic signed [SW-1:0] biased;
        biased = v + (v[SW-1] ? m : '0);
        unique case (md)
            MODE_SCALE:  return biased >>> SCALE_FRAC_BITS;
            MODE_ROTATE: return biased >>> TRIG_FRAC_BITS;
            default:     return v;
        endcase
    endfunction

    // sum stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_ctl_reg <= '0;
        end
        else if (en_sum)
        begin
            sum_ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_sum)
        begin
            sum_x_reg <= SW'(base_x) + SW'(prod[0]) - SW'(prod[1]);
            sum_y_reg <= SW'(base_y) + SW'(prod[2]) + SW'(prod[3]);
        end
    end

    // truncate toward zero, then clamp to the coordinate range
    always_comb
    begin
        unique case (sum_ctl_reg.mode)
            MODE_SCALE:  mask = SCALE_MASK;
            MODE_ROTATE: mask = TRIG_MASK;
            default:     mask = '0;
        endcase
        res_x  = trunc_shift(sum_x_reg, mask, sum_ctl_reg.mode);
        res_y  = trunc_shift(sum_y_reg, mask, sum_ctl_reg.mode);
        clip_x = (res_x > SAT_HI) || (res_x < SAT_LO);
        clip_y = (res_y > SAT_HI) || (res_y < SAT_LO);
        sat_x  = (res_x > SAT_HI) ? SAT_HI[COORD_WIDTH-1:0] :
                 (res_x < SAT_LO) ? SAT_LO[COORD_WIDTH-1:0] : res_x[COORD_WIDTH-1:0];
        sat_y  = (res_y > SAT_HI) ? SAT_HI[COORD_WIDTH-1:0] :
                 (res_y < SAT_LO) ? SAT_LO[COORD_WIDTH-1:0] : res_y[COORD_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ctl_reg <= '0;
        end
        else if (en_out)
        begin
            out_ctl_reg <= sum_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            out_x_reg   <= sat_x;
            out_y_reg   <= sat_y;
            clipped_reg <= clip_x || clip_y;
        end
    end

    assign sum_ctl = sum_ctl_reg;
    assign out_ctl = out_ctl_reg;
    assign out_x   = out_x_reg;
    assign out_y   = out_y_reg;
    assign clipped = clipped_reg;

endmodule

/* sim/tb_vertex_2d_transform.sv */
`timescale 1ns / 1ps

module tb_vertex_2d_transform;

    import vt2d_pkg::*;

    localparam int    CW             = DEF_COORD_WIDTH;
    localparam longint SCALE_ONE     = longint'(1) << DEF_SCALE_FRAC_BITS;
    localparam longint TRIG_ONE      = longint'(1) << DEF_TRIG_FRAC_BITS;
    localparam longint COORD_MAX     = (longint'(1) << (CW - 1)) - 1;
    localparam longint COORD_MIN     = -COORD_MAX - 1;
    localparam int    DRAIN_CYCLES   = 8;
    localparam int    WATCHDOG_LIMIT = 2000;
    localparam int    CHUNKS         = 16;
    localparam int    CHUNK_ITEMS    = 50;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          clip;
        logic          eop;
    } vertex_t;

    class vertex_scoreboard;
        mode_t                  mode;
        logic signed [CW-1:0]   offset_x, offset_y, pivot_x, pivot_y;
        logic signed [SCALE_WIDTH-1:0] scale_x, scale_y;
        logic [ANGLE_WIDTH-1:0] angle;
        vertex_t                expected_q[$];
        int                     errors;

        function new();
            mode     = MODE_TRANSLATE;
            offset_x = '0;
            offset_y = '0;
            scale_x  = SCALE_RESET;
            scale_y  = SCALE_RESET;
            pivot_x  = '0;
            pivot_y  = '0;
            angle    = '0;
            errors   = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [15:0] value);
            case (idx)
                REG_MODE:     mode     = mode_t'(value[1:0]);
                REG_OFFSET_X: offset_x = value[CW-1:0];
                REG_OFFSET_Y: offset_y = value[CW-1:0];
                REG_SCALE_X:  scale_x  = value[SCALE_WIDTH-1:0];
                REG_SCALE_Y:  scale_y  = value[SCALE_WIDTH-1:0];
                REG_PIVOT_X:  pivot_x  = value[CW-1:0];
                REG_PIVOT_Y:  pivot_y  = value[CW-1:0];
                REG_ANGLE:    angle    = value[ANGLE_WIDTH-1:0];
                default: ;
            endcase
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10)
                $display("ERROR: %s", msg);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // table and trig fraction are both 14 bits, so entries are used as they stand
        function longint sine_q14(int unsigned deg);
            int unsigned quadrant, rem;
            longint      mag;
            quadrant = deg / DEG_QUARTER;
            rem      = deg % DEG_QUARTER;
            if (quadrant % 2 == 1)
                mag = longint'(QUARTER_SINE[DEG_QUARTER - rem]);
            else
                mag = longint'(QUARTER_SINE[rem]);
            return (quadrant >= 2) ? -mag : mag;
        endfunction

        function logic [CW-1:0] clamp(longint v, inout bit clip);
            if (v > COORD_MAX)
            begin
                v    = COORD_MAX;
                clip = 1'b1;
            end
            if (v < COORD_MIN)
            begin
                v    = COORD_MIN;
                clip = 1'b1;
            end
            return v[CW-1:0];
        endfunction

        // longint division truncates toward zero, which is the rounding wanted
        function void note_vertex(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                  logic lst);
            longint      rx, ry, px, py, dx, dy, s, c;
            int unsigned a;
            bit          clip;
            vertex_t     v;
            rx   = longint'(x);
            ry   = longint'(y);
            clip = 1'b0;
            case (mode)
                MODE_TRANSLATE:
                begin
                    rx = longint'(x) + longint'(offset_x);
                    ry = longint'(y) + longint'(offset_y);
                end
                MODE_SCALE:
                begin
                    rx = (longint'(x) * longint'(scale_x)) / SCALE_ONE;
                    ry = (longint'(y) * longint'(scale_y)) / SCALE_ONE;
                end
                MODE_ROTATE:
                begin
                    a = angle;
                    if (a >= DEG_FULL)
                        a -= DEG_FULL;
                    s  = sine_q14(a);
                    c  = sine_q14((a + DEG_QUARTER) % DEG_FULL);
                    px = longint'(pivot_x);
                    py = longint'(pivot_y);
                    dx = longint'(x) - px;
                    dy = longint'(y) - py;
                    rx = (px * TRIG_ONE + dx * c - dy * s) / TRIG_ONE;
                    ry = (py * TRIG_ONE + dx * s + dy * c) / TRIG_ONE;
                end
                default: ;
            endcase
            v.x    = clamp(rx, clip);
            v.y    = clamp(ry, clip);
            v.clip = clip;
            v.eop  = lst;
            expected_q.push_back(v);
        endfunction

        function void check_result(vertex_t got);
            vertex_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected word x=%0d y=%0d clip=%0b eop=%0b",
                                 $signed(got.x), $signed(got.y), got.clip, got.eop));
                return;
            end
            want = expected_q.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.clip !== want.clip ||
                got.eop !== want.eop)
                report($sformatf("exp x=%0d y=%0d clip=%0b eop=%0b, got x=%0d y=%0d clip=%0b eop=%0b",
                                 $signed(want.x), $signed(want.y), want.clip, want.eop,
                                 $signed(got.x), $signed(got.y), got.clip, got.eop));
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [15:0]                cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [CW-1:0]       pos_x;
    logic signed [CW-1:0]       pos_y;
    logic                       last_vertex;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [CW-1:0]       out_x;
    logic signed [CW-1:0]       out_y;
    logic                       clipped;
    logic                       end_of_polygon;

    vertex_scoreboard sb;
    int               sender_idle_pct;
    int               recv_stall_pct;
    int               quiet_cycles = 0;

    vertex_2d_transform dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .last_vertex    (last_vertex),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_x          (out_x),
        .out_y          (out_y),
        .clipped        (clipped),
        .end_of_polygon (end_of_polygon)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_vertex(pos_x, pos_y, last_vertex);
            if (out_valid && !out_stall)
                sb.check_result({out_x, out_y, clipped, end_of_polygon});
        end
    end

    // counts cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_vertex(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                               logic lst);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        pos_x       <= x;
        pos_y       <= y;
        last_vertex <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // holds the sender off until every expected word is back
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [15:0] value);
        sb.set_reg(idx, value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // upper bits of the data word are junk the register must drop
    task automatic set_mode(mode_t m);
        logic [15:0] junk;
        junk = $urandom;
        write_reg(REG_MODE, {junk[15:2], m});
    endtask

    task automatic set_angle(int unsigned deg);
        logic [15:0] junk;
        junk = $urandom;
        write_reg(REG_ANGLE, {junk[15:ANGLE_WIDTH], deg[ANGLE_WIDTH-1:0]});
    endtask

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3, 4:    return 16'(int'($urandom_range(1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_scale();
        case ($urandom_range(9))
            0:       return SCALE_RESET;
            1:       return -SCALE_RESET;
            2:       return 16'h7FFF;
            3:       return 16'h8000;
            4:       return 16'h0000;
            5:       return 16'($urandom);
            default: return 16'(int'($urandom_range(2048)) - 1024);
        endcase
    endfunction

    function automatic logic [CW-1:0] pick_vertex_coord();
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3:    return 16'($urandom);
            default: return 16'(int'($urandom_range(1024)) - 512);
        endcase
    endfunction

    task automatic randomize_regs(mode_t m);
        set_mode(m);
        write_reg(REG_OFFSET_X, pick_coord());
        write_reg(REG_OFFSET_Y, pick_coord());
        write_reg(REG_SCALE_X, pick_scale());
        write_reg(REG_SCALE_Y, pick_scale());
        write_reg(REG_PIVOT_X, pick_coord());
        write_reg(REG_PIVOT_Y, pick_coord());
        // now and then an angle past a full turn, which must wrap
        if ($urandom_range(7) == 0)
            set_angle($urandom_range(511, 360));
        else
            set_angle($urandom_range(359));
    endtask

    initial
    begin
        sb              = new();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_valid        = 1'b0;
        pos_x           = '0;
        pos_y           = '0;
        last_vertex     = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // register defaults: translate by zero, unit scale, zero angle
        send_vertex(16'sh7FFF, 16'sh8000, 1'b1);
        send_vertex(-16'sd1, 16'sd0, 1'b0);
        drain();
        set_mode(MODE_SCALE);
        send_vertex(16'sh8000, 16'sd1234, 1'b0);
        drain();
        set_mode(MODE_ROTATE);
        send_vertex(16'sd777, -16'sd888, 1'b1);
        drain();

        // translate to both rails
        set_mode(MODE_TRANSLATE);
        write_reg(REG_OFFSET_X, 16'h7FFF);
        write_reg(REG_OFFSET_Y, 16'h8000);
        send_vertex(16'sh7FFF, 16'sh8000, 1'b0);
        send_vertex(16'sh8000, 16'sh7FFF, 1'b1);
        drain();

        // scale extremes and truncation of negative products
        set_mode(MODE_SCALE);
        write_reg(REG_SCALE_X, 16'h8000);
        write_reg(REG_SCALE_Y, 16'h7FFF);
        send_vertex(16'sh8000, 16'sh8000, 1'b0);
        send_vertex(16'sd1, -16'sd1, 1'b0);
        send_vertex(-16'sd300, 16'sd300, 1'b1);
        drain();

        // rotate about a pivot through the quadrants and past a full turn
        set_mode(MODE_ROTATE);
        write_reg(REG_PIVOT_X, 16'd100);
        write_reg(REG_PIVOT_Y, -16'sd100);
        for (int k = 0; k < 8; k++)
        begin
            case (k)
                0: set_angle(0);
                1: set_angle(45);
                2: set_angle(DEG_QUARTER);
                3: set_angle(DEG_HALF);
                4: set_angle(DEG_3QUART);
                5: set_angle(359);
                6: set_angle(450);
                default: set_angle(511);
            endcase
            send_vertex(16'sd300, 16'sd50, k == 7);
            drain();
        end
        write_reg(REG_PIVOT_X, 16'h7FFF);
        write_reg(REG_PIVOT_Y, 16'h8000);
        set_angle(DEG_HALF);
        send_vertex(16'sh8000, 16'sh7FFF, 1'b0);
        drain();

        // unused mode passes the vertex straight through
        set_mode(MODE_PASS);
        send_vertex(16'sh7FFF, 16'sh8000, 1'b1);
        send_vertex(16'sd123, -16'sd456, 1'b0);
        drain();

        for (int chunk = 0; chunk < CHUNKS; chunk++)
        begin
            case (chunk / 4)
                0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin sender_idle_pct = 67; recv_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin sender_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            randomize_regs(mode_t'(chunk % 4));
            repeat (CHUNK_ITEMS)
                send_vertex(pick_vertex_coord(), pick_vertex_coord(),
                            $urandom_range(4) == 0);
            drain();
        end

        if (sb.pending() != 0)
            sb.report($sformatf("%0d words never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
